### src/tlf_pkg.sv
// Shared types and constants for the text line folder.
package tlf_pkg;

   localparam int CHAR_W = 8;
   localparam int FOLD_W = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   localparam logic [FOLD_W-1:0] FOLD_RESET = 6'd32;
   localparam logic [FOLD_W-1:0] FOLD_MIN = 6'd2;

   // register word index (paddr[2])
   localparam logic REG_FOLD_COLUMN = 1'b0;

   typedef struct packed {
      logic idle;
      logic [FOLD_W-1:0] fill;
   } tlf_stat_type;

endpackage

### src/text_line_folder_core.sv
// Text line folder: one character per request in, folded character stream out.
//
// Channels: req_* carries one character per request (valid/ready). rsp_* carries
// one emitted character per result, with rsp_last_of_run set on the final result
// of a request. The csr_* port (APB-style) holds fold_column at byte address 0.
// A plain character is absorbed on acceptance; a tab, which adds fewer than
// TAB_WIDTH spaces, holds the input while the spaces are written. A request that
// emits a line streams its characters from the line RAM read port through the
// output register, one character per cycle while the receiver keeps up, then
// the newline; a fold that keeps a tail of characters copies that tail to the
// front of the RAM before the next request is accepted.
// Only one request is in work at a time; req_ready is high when the sequencer
// is idle, even while the last result still sits in the output register.
// Reset: synchronous, active high; the buffer is empty and fold_column is 32.
// The line RAM needs no clearing, since only written entries are read.
// A stalled receiver holds the output register; the sequencer waits on it
// and the read data stays in the RAM output register meanwhile.
module text_line_folder_core import tlf_pkg::*; #(
   parameter int LINE_COLS = 32,
   parameter int TAB_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_W-1:0]     req_in_char,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic                  rsp_last_of_run,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(LINE_COLS);

   logic [FOLD_W-1:0] fold_column;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [CHAR_W-1:0] ram_wdata;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   logic [CHAR_W-1:0] ram_rdata;
   tlf_stat_type      stat;

   tlf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fold_column (fold_column)
   );

   tlf_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LINE_COLS)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tlf_seq #(
      .LINE_COLS (LINE_COLS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .fold_column (fold_column),
      .req_valid   (req_valid),
      .req_char    (req_in_char),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_char    (rsp_out_char),
      .rsp_last    (rsp_last_of_run),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .stat        (stat)
   );

   assign req_ready = stat.idle;

`ifndef NO_ASSERTIONS
   // fill stays below the buffer size between and during requests
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.fill < FOLD_W'(LINE_COLS))
      else $error("line fill reached buffer size");

   // every run of results ends with the newline
   a_last_is_nl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> (rsp_out_char == CH_NL))
      else $error("last result of a request is not a newline");

   // a newline on a non-empty line must start a flush
   a_nl_flush: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_in_char == CH_NL && stat.fill != '0) |=> !req_ready)
      else $error("newline on a non-empty line did not flush");
`endif

endmodule

### src/tlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/tlf_csr.sv
// APB-style configuration register block holding the fold column.
module tlf_csr import tlf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [FOLD_W-1:0]     fold_column
);

   logic [FOLD_W-1:0] fold_ff;
   logic [FOLD_W-1:0] fold_in;
   logic              wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      fold_in = fold_ff;
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_FOLD_COLUMN: begin
            if (wr_en) begin
               fold_in = csr_pwdata[FOLD_W-1:0];
            end
            csr_prdata = {{(CSR_DATA_W-FOLD_W){1'b0}}, fold_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= FOLD_RESET;
      end else begin
         fold_ff <= fold_in;
      end
   end

   assign csr_pready = 1'b1;
   assign fold_column = fold_ff;

endmodule

### src/tlf_seq.sv
// Folding sequencer: buffers characters in the line RAM and streams lines out.
module tlf_seq import tlf_pkg::*; #(
   parameter int LINE_COLS = 32,
   parameter int TAB_WIDTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [FOLD_W-1:0]            fold_column,
   input  logic                         req_valid,
   input  logic [CHAR_W-1:0]            req_char,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [CHAR_W-1:0]            rsp_char,
   output logic                         rsp_last,
   output logic                         ram_we,
   output logic [$clog2(LINE_COLS)-1:0] ram_waddr,
   output logic [CHAR_W-1:0]            ram_wdata,
   output logic                         ram_re,
   output logic [$clog2(LINE_COLS)-1:0] ram_raddr,
   input  logic [CHAR_W-1:0]            ram_rdata,
   output tlf_stat_type                 stat
);

   localparam int IDX_W = $clog2(LINE_COLS);
   localparam int CNT_W = $clog2(LINE_COLS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TABF = 3'd1;
   localparam logic [2:0] S_EMIT = 3'd2;
   localparam logic [2:0] S_ENL  = 3'd3;
   localparam logic [2:0] S_MOVE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] lspace_ff, lspace_in;   // index+1 of last buffered space, 0 if none
   logic [CNT_W-1:0] pos_ff, pos_in;         // tab position, or end of fill during a fold
   logic [CNT_W-1:0] count_ff, count_in;     // characters emitted before the newline
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic             pend_ff, pend_in;       // RAM read data is waiting
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0] fold_eff;
   logic [CNT_W-1:0] pos_cur;
   logic [CNT_W-1:0] pos_inc;
   logic [CNT_W-1:0] ls_new;
   logic             accept;
   logic             out_free;
   logic             load;
   logic             rd_more;
   logic             issue;

   always_comb begin
      if (fold_column < FOLD_MIN) begin
         fold_eff = CNT_W'(FOLD_MIN);
      end else if (fold_column > FOLD_W'(LINE_COLS)) begin
         fold_eff = CNT_W'(LINE_COLS);
      end else begin
         fold_eff = fold_column[CNT_W-1:0];
      end
   end

   assign pos_cur = (fill_ff >= CNT_W'(LINE_COLS)) ? CNT_W'(LINE_COLS - 1) : fill_ff;
   assign pos_inc = pos_cur + 1'b1;
   assign ls_new = (req_char == CH_SPACE) ? pos_inc : lspace_ff;
   assign accept = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load = pend_ff && out_free;
   assign rd_more = rd_ff < count_ff;
   assign issue = rd_more && (!pend_ff || load);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      lspace_in = lspace_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      pend_in = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re = 1'b0;
      ram_raddr = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_char)
                  CH_TAB: begin
                     if (pos_cur < fold_eff && (pos_cur % TAB_WIDTH) != 0) begin
                        ram_we = 1'b1;
                        ram_waddr = pos_cur[IDX_W-1:0];
                        ram_wdata = CH_SPACE;
                        pos_in = pos_inc;
                        lspace_in = pos_inc;
                        state_in = S_TABF;
                     end else if (pos_cur >= fold_eff) begin
                        count_in = pos_cur;
                        pos_in = pos_cur;
                        fill_in = '0;
                        lspace_in = '0;
                        rd_in = '0;
                        pend_in = 1'b0;
                        state_in = S_EMIT;
                     end else begin
                        fill_in = pos_cur;
                     end
                  end
                  CH_NL: begin
                     if (pos_cur != '0) begin
                        count_in = pos_cur;
                        pos_in = pos_cur;
                        rd_in = '0;
                        pend_in = 1'b0;
                        state_in = S_EMIT;
                     end
                     fill_in = '0;
                     lspace_in = '0;
                  end
                  default: begin
                     ram_we = 1'b1;
                     ram_waddr = pos_cur[IDX_W-1:0];
                     ram_wdata = req_char;
                     if (pos_inc >= fold_eff) begin
                        // break after the last space, or emit the whole line
                        pos_in = pos_inc;
                        if (ls_new == '0) begin
                           count_in = pos_inc;
                           fill_in = '0;
                        end else begin
                           count_in = ls_new;
                           fill_in = pos_inc - ls_new;
                        end
                        lspace_in = '0;
                        rd_in = '0;
                        pend_in = 1'b0;
                        state_in = S_EMIT;
                     end else begin
                        fill_in = pos_inc;
                        lspace_in = ls_new;
                     end
                  end
               endcase
            end
         end
         S_TABF: begin
            if (pos_ff < fold_eff && (pos_ff % TAB_WIDTH) != 0) begin
               ram_we = 1'b1;
               ram_waddr = pos_ff[IDX_W-1:0];
               ram_wdata = CH_SPACE;
               pos_in = pos_ff + 1'b1;
               lspace_in = pos_ff + 1'b1;
            end else if (pos_ff >= fold_eff) begin
               count_in = pos_ff;
               fill_in = '0;
               lspace_in = '0;
               rd_in = '0;
               pend_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               fill_in = pos_ff;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = ram_rdata;
               rsp_last_in = 1'b0;
            end
            if (issue) begin
               ram_re = 1'b1;
               ram_raddr = rd_ff[IDX_W-1:0];
               rd_in = rd_ff + 1'b1;
               pend_in = 1'b1;
            end else if (load) begin
               pend_in = 1'b0;
            end
            if (!rd_more && (!pend_ff || load)) begin
               state_in = S_ENL;
            end
         end
         S_ENL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = CH_NL;
               rsp_last_in = 1'b1;
               if (count_ff < pos_ff) begin
                  rd_in = count_ff;
                  wr_in = '0;
                  pend_in = 1'b0;
                  state_in = S_MOVE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MOVE: begin
            // read ahead of the write pointer; writes only land below the reads
            if (pend_ff) begin
               ram_we = 1'b1;
               ram_waddr = wr_ff[IDX_W-1:0];
               ram_wdata = ram_rdata;
               wr_in = wr_ff + 1'b1;
            end
            if (rd_ff < pos_ff) begin
               ram_re = 1'b1;
               ram_raddr = rd_ff[IDX_W-1:0];
               rd_in = rd_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         lspace_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         lspace_ff <= lspace_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      count_ff <= count_in;
      rd_ff <= rd_in;
      wr_ff <= wr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char = rsp_char_ff;
   assign rsp_last = rsp_last_ff;
   assign stat.idle = (state_ff == S_IDLE);
   assign stat.fill = FOLD_W'(fill_ff);

endmodule
